FILE: rtl/fourier_series_waveform_synth_defines.svh
// Assertion macros for the waveform synthesizer checker.
`ifndef FOURIER_SERIES_WAVEFORM_SYNTH_DEFINES_SVH
`define FOURIER_SERIES_WAVEFORM_SYNTH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FSWS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FSWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fsws_pkg.sv
package fsws_pkg;

    localparam int HARMONICS      = 8;
    localparam int COS_TABLE_BITS = 10;
    localparam int QTR_W          = COS_TABLE_BITS - 2;
    localparam int QUARTER        = 1 << QTR_W;
    localparam int CUSTOM_SLOTS   = 8;
    localparam int CUSTOM_TERMS   = (HARMONICS < CUSTOM_SLOTS) ? HARMONICS : CUSTOM_SLOTS;
    localparam int IDX_W          = ($clog2(HARMONICS) > 3) ? $clog2(HARMONICS) : 3;
    localparam int ROM_DEPTH      = 1 << IDX_W;
    localparam int ACC_W          = 31 + $clog2(HARMONICS + 1);
    localparam int PRE_W          = ACC_W - 15;
    localparam int MUL_A_W        = 33;
    localparam int MUL_B_W        = 17;
    localparam int MUL_P_W        = MUL_A_W + MUL_B_W;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 4;

    localparam logic [63:0] HALF_PI_Q30        = 64'd1686629713;
    localparam logic [63:0] FOUR_OVER_PI_Q30   = 64'd1367130551;
    localparam logic [63:0] TWO_OVER_PI_Q30    = 64'd683565276;
    localparam logic [63:0] EIGHT_OVER_PI2_Q30 = 64'd870341787;
    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;

    localparam logic signed [MUL_P_W-1:0] SAMPLE_MAX = MUL_P_W'(32767);
    localparam logic signed [MUL_P_W-1:0] SAMPLE_MIN = -MUL_P_W'(32768);

    localparam logic [2:0] WAVE_CUSTOM    = 3'd0;
    localparam logic [2:0] WAVE_SQUARE    = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE  = 3'd2;
    localparam logic [2:0] WAVE_SAW_LEFT  = 3'd3;
    localparam logic [2:0] WAVE_SAW_RIGHT = 3'd4;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] REG_WAVE_TYPE  = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [1:0] REG_DC_OFFSET  = 2'd2;
    localparam logic [1:0] REG_GAIN       = 2'd3;

    typedef struct packed {
        logic [2:0]         wave_type;
        logic [31:0]        phase_step;
        logic signed [15:0] dc_offset;
        logic signed [15:0] gain;
    } cfg_t;

    typedef logic [QUARTER:0][14:0] cos_tab_t;
    typedef logic [3:0][ROM_DEPTH-1:0][15:0] coef_rom_t;

    // Shift-and-subtract division, used only while building the tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave cosine in Q1.14 from an eleven-term Taylor series in Q30.
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t           tab;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        tab = '0;
        for (int i = 0; i <= QUARTER; i++)
        begin
            t    = (64'(i) * HALF_PI_Q30) >> QTR_W;
            t2   = (t * t) >> 30;
            term = 64'd1 << 30;
            sum  = signed'(term);
            for (int n = 1; n <= 10; n++)
            begin
                term = udiv64((term * t2) >> 30, 64'((2 * n - 1) * (2 * n)));
                if ((n & 1) == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            e = (64'(sum) + (64'd1 << 15)) >> 16;
            if (e > 64'd16384)
            begin
                e = 64'd16384;
            end
            tab[i] = e[14:0];
        end
        return tab;
    endfunction

    // Harmonic coefficients in Q2.14, rows square, triangle, saw left, saw right.
    function automatic coef_rom_t build_coef_rom();
        coef_rom_t   rom;
        logic [63:0] k;
        logic [63:0] mag;
        logic        pos;
        rom = '0;
        for (int w = 0; w < 4; w++)
        begin
            for (int i = 1; i < HARMONICS; i++)
            begin
                if (w < 2)
                begin
                    k = 64'(2 * i - 1);
                end
                else
                begin
                    k = 64'(i);
                end
                case (w)
                    0:
                    begin
                        mag = (udiv64(FOUR_OVER_PI_Q30, k) + (64'd1 << 15)) >> 16;
                        pos = 1'b1;
                    end
                    1:
                    begin
                        mag = (udiv64(EIGHT_OVER_PI2_Q30, k * k) + (64'd1 << 15)) >> 16;
                        pos = ((i & 1) == 1);
                    end
                    2:
                    begin
                        mag = (udiv64(TWO_OVER_PI_Q30, k) + (64'd1 << 15)) >> 16;
                        pos = ((i & 1) == 1);
                    end
                    default:
                    begin
                        mag = (udiv64(TWO_OVER_PI_Q30, k) + (64'd1 << 15)) >> 16;
                        pos = ((i & 1) == 0);
                    end
                endcase
                rom[w][i] = pos ? mag[15:0] : (16'd0 - mag[15:0]);
            end
        end
        return rom;
    endfunction

    localparam cos_tab_t  COS_TAB   = build_cos_tab();
    localparam coef_rom_t COEF_ROM  = build_coef_rom();

endpackage

FILE: rtl/fsws_regs.sv
module fsws_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output fsws_pkg::cfg_t                    cfg
);
    import fsws_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_sel;

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_WAVE_TYPE:  cfg_next.wave_type  = pwdata[2:0];
                REG_PHASE_STEP: cfg_next.phase_step = pwdata;
                REG_DC_OFFSET:  cfg_next.dc_offset  = signed'(pwdata[15:0]);
                REG_GAIN:       cfg_next.gain       = signed'(pwdata[15:0]);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WAVE_TYPE:  prdata = {29'd0, cfg_reg.wave_type};
            REG_PHASE_STEP: prdata = cfg_reg.phase_step;
            REG_DC_OFFSET:  prdata = {16'd0, cfg_reg.dc_offset};
            REG_GAIN:       prdata = {16'd0, cfg_reg.gain};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_type  <= WAVE_CUSTOM;
            cfg_reg.phase_step <= 32'd0;
            cfg_reg.dc_offset  <= 16'sd0;
            cfg_reg.gain       <= 16'sd4096;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/fsws_cos_lut.sv
module fsws_cos_lut (
    input  logic               clk,
    input  logic [31:0]        angle,
    output logic signed [15:0] cos_val
);
    import fsws_pkg::*;

    logic [COS_TABLE_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QTR_W-1:0]          pos;
    logic [QTR_W-1:0]          addr;
    logic                      at_end;
    logic [14:0]               mag_reg;
    logic                      neg_reg;
    logic signed [15:0]        mag_ext;

    assign idx    = angle[31 -: COS_TABLE_BITS];
    assign quad   = idx[COS_TABLE_BITS-1 -: 2];
    assign pos    = idx[QTR_W-1:0];
    assign addr   = quad[0] ? ({QTR_W{1'b0}} - pos) : pos;
    assign at_end = quad[0] && (pos == {QTR_W{1'b0}});

    always_ff @(posedge clk)
    begin
        if (at_end)
        begin
            mag_reg <= COS_TAB[QUARTER];
        end
        else
        begin
            mag_reg <= COS_TAB[addr];
        end
        neg_reg <= quad[0] ^ quad[1];
    end

    assign mag_ext = signed'({1'b0, mag_reg});
    assign cos_val = neg_reg ? (16'sd0 - mag_ext) : mag_ext;

endmodule

FILE: rtl/fsws_mul.sv
module fsws_mul (
    input  logic                                  clk,
    input  logic signed [fsws_pkg::MUL_A_W-1:0]   a,
    input  logic signed [fsws_pkg::MUL_B_W-1:0]   b,
    output logic signed [fsws_pkg::MUL_P_W-1:0]   p
);
    import fsws_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

FILE: rtl/fourier_series_waveform_synth.sv
// Additive waveform synthesizer: a tick request (tuser 0) yields one saturated Q5.11 sample
// built from up to eight custom harmonics or the built-in square, triangle and sawtooth
// series, plus dc offset, times gain; a write request (tuser 1) loads one custom slot and
// yields nothing, and the block stays ready for the next request. A tick runs S_ANGLE,
// S_LOOK, S_PROD and S_ACC for each of N terms (8 in custom mode, HARMONICS-1 for the
// built-in series, 0 for an unknown wave type), then S_RND and S_GAIN, where the result
// register loads. The single shared multiplier is used once for the harmonic angle and once
// for the term product, with the registered cosine ROM in between, and then for the gain.
// s_tready is high only between ticks; a finished sample waits in the output register, and
// the next tick finishes only once it has been taken.
module fourier_series_waveform_synth (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[2:0], harmonic_number[10:3], amplitude[26:11], phase_offset[42:27]
    input  logic [fsws_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sample[15:0]
    output logic [fsws_pkg::M_TDATA_W-1:0]    m_tdata,
    // saturated[0]
    output logic [0:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsws_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import fsws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANGLE,
        S_LOOK,
        S_PROD,
        S_ACC,
        S_RND,
        S_GAIN
    } state_t;

    cfg_t cfg;

    state_t                   state_reg,    state_next;
    logic [IDX_W-1:0]         idx_reg,      idx_next;
    logic signed [ACC_W-1:0]  sum_reg,      sum_next;
    logic [31:0]              phase_reg,    phase_next;
    logic signed [15:0]       amp_reg,      amp_next;
    logic [31:0]              beta_reg,     beta_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [15:0]              m_tdata_reg,  m_tdata_next;
    logic                     m_tuser_reg,  m_tuser_next;

    logic [7:0]               harm_tab [CUSTOM_SLOTS];
    logic signed [15:0]       amp_tab  [CUSTOM_SLOTS];
    logic [15:0]              pha_tab  [CUSTOM_SLOTS];

    logic                     accept;
    logic                     in_op;
    logic [2:0]               in_index;
    logic [7:0]               in_harm;
    logic [15:0]              in_amp;
    logic [15:0]              in_pha;

    logic                     is_custom;
    logic                     is_rom;
    logic [1:0]               rom_sel;
    logic [2:0]               slot;
    logic [7:0]               term_k;
    logic signed [15:0]       term_amp;
    logic [31:0]              term_beta;
    logic [IDX_W-1:0]         last_idx;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [31:0]               angle;
    logic signed [15:0]        cos_val;

    logic signed [ACC_W:0]     sum_rnd;
    logic signed [PRE_W-1:0]   pre_val;
    logic signed [MUL_P_W-1:0] y_rnd;
    logic signed [MUL_P_W-1:0] y_full;
    logic [15:0]               y_sample;
    logic                      y_sat;

    fsws_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fsws_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fsws_cos_lut u_cos (
        .clk     (clk),
        .angle   (angle),
        .cos_val (cos_val)
    );

    assign in_op    = s_tuser[0];
    assign in_index = s_tdata[2:0];
    assign in_harm  = s_tdata[10:3];
    assign in_amp   = s_tdata[26:11];
    assign in_pha   = s_tdata[42:27];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        is_custom = (cfg.wave_type == WAVE_CUSTOM);
        is_rom    = cfg.wave_type inside {[WAVE_SQUARE:WAVE_SAW_RIGHT]};
        rom_sel   = 2'(cfg.wave_type - WAVE_SQUARE);
        slot      = idx_reg[2:0];
        if (is_custom)
        begin
            term_k    = harm_tab[slot];
            term_amp  = amp_tab[slot];
            term_beta = {pha_tab[slot], 16'h0000};
            last_idx  = IDX_W'(CUSTOM_TERMS - 1);
        end
        else
        begin
            term_k    = rom_sel[1] ? 8'(idx_reg) : (8'({idx_reg, 1'b0}) - 8'd1);
            term_amp  = signed'(COEF_ROM[rom_sel][idx_reg]);
            term_beta = QUARTER_TURN;
            last_idx  = IDX_W'(HARMONICS - 1);
        end
    end

    always_comb
    begin
        sum_rnd  = (ACC_W + 1)'(sum_reg) + (ACC_W + 1)'(65536);
        pre_val  = PRE_W'(signed'(sum_rnd[ACC_W:17])) + PRE_W'(signed'(cfg.dc_offset));
        y_rnd    = mul_p + MUL_P_W'(2048);
        y_full   = y_rnd >>> 12;
        y_sat    = 1'b0;
        y_sample = y_full[15:0];
        if (y_full > SAMPLE_MAX)
        begin
            y_sample = 16'h7FFF;
            y_sat    = 1'b1;
        end
        else if (y_full < SAMPLE_MIN)
        begin
            y_sample = 16'h8000;
            y_sat    = 1'b1;
        end
    end

    assign angle = mul_p[31:0] + beta_reg;

    always_comb
    begin
        case (state_reg)
            S_PROD:
            begin
                mul_a = MUL_A_W'(cos_val);
                mul_b = MUL_B_W'(amp_reg);
            end
            S_RND, S_GAIN:
            begin
                mul_a = MUL_A_W'(pre_val);
                mul_b = MUL_B_W'(signed'(cfg.gain));
            end
            default:
            begin
                mul_a = signed'({1'b0, phase_reg});
                mul_b = signed'({9'd0, term_k});
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        phase_next    = phase_reg;
        amp_next      = amp_reg;
        beta_next     = beta_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_op == OP_TICK))
                begin
                    sum_next = '0;
                    if (is_custom)
                    begin
                        idx_next   = '0;
                        state_next = S_ANGLE;
                    end
                    else if (is_rom)
                    begin
                        idx_next   = IDX_W'(1);
                        state_next = S_ANGLE;
                    end
                    else
                    begin
                        state_next = S_RND;
                    end
                end
            end
            S_ANGLE:
            begin
                amp_next   = term_amp;
                beta_next  = term_beta;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_reg + ACC_W'(mul_p);
                if (idx_reg == last_idx)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_ANGLE;
                end
            end
            S_RND:
            begin
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = y_sample;
                    m_tuser_next  = y_sat;
                    phase_next    = phase_reg + cfg.phase_step;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            sum_reg      <= '0;
            phase_reg    <= 32'd0;
            amp_reg      <= 16'sd0;
            beta_reg     <= 32'd0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 16'd0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            phase_reg    <= phase_next;
            amp_reg      <= amp_next;
            beta_reg     <= beta_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CUSTOM_SLOTS; i++)
            begin
                harm_tab[i] <= 8'd0;
                amp_tab[i]  <= 16'sd0;
                pha_tab[i]  <= 16'd0;
            end
        end
        else if (accept && (in_op == OP_WRITE))
        begin
            harm_tab[in_index] <= in_harm;
            amp_tab[in_index]  <= signed'(in_amp);
            pha_tab[in_index]  <= in_pha;
        end
    end

endmodule

FILE: rtl/fsws_checker.sv
`include "fourier_series_waveform_synth_defines.svh"

module fsws_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [0:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fsws_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                        m_tuser
);
    import fsws_pkg::*;

    `FSWS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `FSWS_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && (s_tuser[0] == OP_TICK), !s_tready, "ready after tick request")
    `FSWS_ASSERT_NEXT(a_write_silent, s_tvalid && s_tready && (s_tuser[0] == OP_WRITE) && !m_tvalid, !m_tvalid, "write request produced a result")
    `FSWS_ASSERT_SAME(a_sat_value, m_tvalid && m_tuser[0], (m_tdata == 16'h7FFF) || (m_tdata == 16'h8000), "saturated flag on unclipped sample")
    `FSWS_ASSERT_SAME(a_result_after_busy, $rose(m_tvalid), $past(!s_tready), "result without a tick in progress")

endmodule

bind fourier_series_waveform_synth fsws_checker u_checker (.*);

FILE: bench/tb_fourier_series_waveform_synth.sv
module tb_fourier_series_waveform_synth;
    timeunit 1ns;
    timeprecision 1ps;

    import fsws_pkg::*;

    localparam longint unsigned HALF_PI_FX     = 64'd1686629713;
    localparam longint unsigned FOUR_PI_FX     = 64'd1367130551;
    localparam longint unsigned TWO_PI_FX      = 64'd683565276;
    localparam longint unsigned EIGHT_PI2_FX   = 64'd870341787;
    localparam logic [31:0]     QTR_TURN       = 32'h4000_0000;
    localparam int              SETTLE_CYCLES  = 48;
    localparam int              RANDOM_PHASES  = 14;
    localparam int              PHASE_REQUESTS = 125;

    typedef struct packed {
        logic               op;
        logic [2:0]         slot;
        logic [7:0]         harm;
        logic signed [15:0] amp;
        logic [15:0]        pha;
    } synth_req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               saturated;
    } synth_out_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int cos_q [0:QUARTER];

    logic [2:0]         cur_wave  = WAVE_CUSTOM;
    logic [31:0]        cur_step  = '0;
    logic signed [15:0] cur_dc    = '0;
    logic signed [15:0] cur_gain  = 16'sd4096;
    logic [31:0]        phase_acc = '0;
    logic [7:0]         slot_harm [CUSTOM_SLOTS] = '{default: '0};
    logic signed [15:0] slot_amp  [CUSTOM_SLOTS] = '{default: '0};
    logic [15:0]        slot_pha  [CUSTOM_SLOTS] = '{default: '0};

    synth_req_t request_q [$];
    synth_out_t expected_q [$];

    bit idle_mode       = 1'b1;
    int src_gap         = 0;
    int sink_gap        = 0;
    int queued_count    = 0;
    int accepted_count  = 0;
    int loads_count     = 0;
    int samples_checked = 0;
    int clipped_count   = 0;
    int setting_count   = 0;
    int fail_count      = 0;

    fourier_series_waveform_synth u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic void build_cos_quarter();
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned e;
        longint          sum;
        for (int i = 0; i <= QUARTER; i++)
        begin
            t    = (64'(i) * HALF_PI_FX) / 64'(QUARTER);
            t2   = (t * t) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            e = (unsigned'(sum) + (64'd1 << 15)) >> 16;
            if (e > 64'd16384)
            begin
                e = 64'd16384;
            end
            cos_q[i] = int'(e);
        end
    endfunction

    function automatic int cos_at(input logic [31:0] angle);
        logic [COS_TABLE_BITS-1:0] idx;
        int                        pos;
        idx = angle[31 -: COS_TABLE_BITS];
        pos = int'(idx[COS_TABLE_BITS-3:0]);
        case (idx[COS_TABLE_BITS-1 -: 2])
            2'd0:    return cos_q[pos];
            2'd1:    return -cos_q[QUARTER - pos];
            2'd2:    return -cos_q[pos];
            default: return cos_q[QUARTER - pos];
        endcase
    endfunction

    function automatic void series_coef(input logic [2:0] wave, input int i,
                                        output int k, output int b);
        longint unsigned mag;
        logic            pos;
        case (wave)
            WAVE_SQUARE:
            begin
                k   = 2 * i - 1;
                mag = ((FOUR_PI_FX / 64'(k)) + (64'd1 << 15)) >> 16;
                pos = 1'b1;
            end
            WAVE_TRIANGLE:
            begin
                k   = 2 * i - 1;
                mag = ((EIGHT_PI2_FX / 64'(k * k)) + (64'd1 << 15)) >> 16;
                pos = (i % 2) == 1;
            end
            WAVE_SAW_LEFT:
            begin
                k   = i;
                mag = ((TWO_PI_FX / 64'(k)) + (64'd1 << 15)) >> 16;
                pos = (i % 2) == 1;
            end
            default:
            begin
                k   = i;
                mag = ((TWO_PI_FX / 64'(k)) + (64'd1 << 15)) >> 16;
                pos = (i % 2) == 0;
            end
        endcase
        b = pos ? int'(mag) : -int'(mag);
    endfunction

    // Sum the harmonics at the current phase, then advance the phase.
    function automatic synth_out_t next_sample();
        synth_out_t  r;
        longint      total;
        longint      pre;
        longint      y;
        logic [31:0] angle;
        int          k;
        int          b;
        total = 0;
        if (cur_wave == WAVE_CUSTOM)
        begin
            for (int i = 0; i < CUSTOM_TERMS; i++)
            begin
                angle = 32'(slot_harm[i]) * phase_acc + {slot_pha[i], 16'h0000};
                total = total + longint'(slot_amp[i]) * longint'(cos_at(angle));
            end
        end
        else if (cur_wave <= WAVE_SAW_RIGHT)
        begin
            for (int i = 1; i < HARMONICS; i++)
            begin
                series_coef(cur_wave, i, k, b);
                angle = 32'(k & 255) * phase_acc + QTR_TURN;
                total = total + longint'(b) * longint'(cos_at(angle));
            end
        end
        pre = ((total + 64'sd65536) >>> 17) + longint'(cur_dc);
        y   = ((pre * longint'(cur_gain)) + 64'sd2048) >>> 12;
        r.saturated = 1'b0;
        if (y > 32767)
        begin
            y           = 32767;
            r.saturated = 1'b1;
        end
        else if (y < -32768)
        begin
            y           = -32768;
            r.saturated = 1'b1;
        end
        r.sample  = y[15:0];
        phase_acc = phase_acc + cur_step;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        synth_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                req = request_q.pop_front();
                s_tdata  <= {5'b0, req.pha, req.amp, req.harm, req.slot};
                s_tuser  <= req.op;
                s_tvalid <= 1'b1;
                src_gap = idle_mode ? idle_len() : 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_mode && $urandom_range(0, 2) == 0)
            begin
                sink_gap = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin : track_requests
        synth_out_t predicted;
        if (rst_n && s_tvalid && s_tready)
        begin
            accepted_count++;
            if (s_tuser[0] == OP_WRITE)
            begin
                slot_harm[s_tdata[2:0]] = s_tdata[10:3];
                slot_amp[s_tdata[2:0]]  = s_tdata[26:11];
                slot_pha[s_tdata[2:0]]  = s_tdata[42:27];
                loads_count++;
            end
            else
            begin
                predicted = next_sample();
                if (predicted.saturated)
                begin
                    clipped_count++;
                end
                expected_q.push_back(predicted);
            end
        end
    end

    always @(posedge clk)
    begin : check_samples
        synth_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("sample %0d arrived with none pending", $signed(m_tdata));
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                samples_checked++;
                if (m_tdata !== want.sample)
                begin
                    $error("sample: expected %0d, actual %0d", want.sample, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser[0] !== want.saturated)
                begin
                    $error("saturated: expected %0d, actual %0d", want.saturated, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WAVE_TYPE:  cur_wave = value[2:0];
            REG_PHASE_STEP: cur_step = value;
            REG_DC_OFFSET:  cur_dc   = value[15:0];
            default:        cur_gain = value[15:0];
        endcase
    endtask

    task automatic load_regs(input logic [2:0] wave, input logic [31:0] step_val,
                             input logic signed [15:0] dc, input logic signed [15:0] gain);
        reg_write(REG_WAVE_TYPE, {29'b0, wave});
        reg_write(REG_PHASE_STEP, step_val);
        reg_write(REG_DC_OFFSET, {16'b0, dc});
        reg_write(REG_GAIN, {16'b0, gain});
        setting_count++;
        @(negedge clk);
    endtask

    task automatic add_request(input logic op, input logic [2:0] slot, input logic [7:0] harm,
                               input logic [15:0] amp, input logic [15:0] pha);
        request_q.push_back('{op: op, slot: slot, harm: harm, amp: amp, pha: pha});
        queued_count++;
    endtask

    task automatic add_random(input int write_pct);
        logic [7:0]  harm;
        logic [15:0] amp;
        if ($urandom_range(0, 3) == 0)
        begin
            harm = 8'($urandom_range(0, 255));
        end
        else
        begin
            harm = 8'($urandom_range(0, 16));
        end
        case ($urandom_range(0, 7))
            0:       amp = 16'h7FFF;
            1:       amp = 16'h8000;
            default: amp = 16'($urandom);
        endcase
        add_request(($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_TICK,
                    3'($urandom_range(0, 7)), harm, amp, 16'($urandom));
    endtask

    // Hold until every request is taken and every sample is back, then let the pipe settle.
    task automatic drain();
        do
            @(negedge clk);
        while (accepted_count != queued_count || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [2:0]         wave;
        logic [31:0]        step_val;
        logic signed [15:0] dc;
        logic signed [15:0] gain;
        int                 write_pct;
        build_cos_quarter();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: empty table, then constant term, top harmonic and extremes.
        add_request(OP_TICK,  3'd0, 8'd0,   16'h0000, 16'h0000);
        add_request(OP_WRITE, 3'd0, 8'd0,   16'h7FFF, 16'h0000);
        add_request(OP_WRITE, 3'd1, 8'd255, 16'h8000, 16'hFFFF);
        add_request(OP_WRITE, 3'd2, 8'd1,   16'h4000, 16'h4000);
        add_request(OP_WRITE, 3'd7, 8'd8,   16'hFFFF, 16'h8000);
        add_request(OP_TICK,  3'd7, 8'd255, 16'hFFFF, 16'hFFFF);
        add_request(OP_WRITE, 3'd3, 8'd2,   16'h3039, 16'h1234);
        add_request(OP_TICK,  3'd0, 8'd0,   16'h0000, 16'h0000);
        drain();

        load_regs(WAVE_CUSTOM, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
        repeat (3) add_request(OP_TICK, 3'd0, 8'd0, 16'h0000, 16'h0000);
        drain();
        load_regs(WAVE_CUSTOM, 32'hFFFF_FFFF, -16'sh8000, 16'sh7FFF);
        repeat (2) add_request(OP_TICK, 3'd0, 8'd0, 16'h0000, 16'h0000);
        drain();

        // Built-in series, then an undefined type with zero step and most negative gain.
        for (int w = WAVE_SQUARE; w <= WAVE_SAW_RIGHT + 1; w++)
        begin
            if (w > WAVE_SAW_RIGHT)
            begin
                load_regs(3'(w), 32'h0, 16'sd12345, -16'sh8000);
            end
            else
            begin
                load_regs(3'(w), 32'h0800_0000, 16'sd1000, 16'sd4096);
            end
            repeat (2) add_request(OP_TICK, 3'd0, 8'd0, 16'h0000, 16'h0000);
            drain();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            idle_mode = (p % 4) != 3;
            if (p == 6 || p == RANDOM_PHASES - 1)
            begin
                wave = 3'($urandom_range(5, 7));
            end
            else
            begin
                wave = 3'(p % 5);
            end
            case ($urandom_range(0, 5))
                0:       step_val = 32'h0;
                1:       step_val = 32'hFFFF_FFFF;
                default: step_val = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       dc = -16'sh8000;
                1:       dc = 16'sh7FFF;
                default: dc = 16'($urandom_range(0, 4095) - 2048);
            endcase
            case ($urandom_range(0, 6))
                0:       gain = -16'sh8000;
                1:       gain = 16'sh7FFF;
                2:       gain = 16'sd4096;
                3:       gain = 16'sd0;
                default: gain = 16'($urandom);
            endcase
            load_regs(wave, step_val, dc, gain);
            write_pct = (wave == WAVE_CUSTOM) ? 30 : 10;
            repeat (PHASE_REQUESTS / 2) add_random(write_pct);
            if (p == 2)
            begin
                drain();
            end
            repeat (PHASE_REQUESTS - PHASE_REQUESTS / 2) add_random(write_pct);
            drain();
        end

        $display("Ran %0d requests (%0d slot loads) over %0d register settings",
                 queued_count, loads_count, setting_count);
        $display("Checked %0d samples, %0d of them clipped", samples_checked, clipped_count);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
